### rtl/core/rlfp_pkg.sv
// rc link frame parser: shared types, constants and the crc step
`timescale 1ns / 1ps
package rlfp_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CHANNEL_BITS = 11;
    localparam int STORE_DEPTH = 22;
    localparam int STORE_AW = 5;
    localparam int ACC_W = CHANNEL_BITS + 7;
    localparam int ACC_CNT_W = 5;

    localparam logic [5:0] CHANNEL_FRAME_LEN = 6'd24;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam logic [7:0] SYNC_RESET = 8'hC8;
    localparam logic [5:0] MAX_LEN_RESET = 6'd62;
    localparam logic [7:0] TYPE_RESET = 8'h16;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_SYNC = 2'd0,
        REG_MAX_LEN = 2'd1,
        REG_CH_TYPE = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN = 3'd1,
        PH_TYPE = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC = 3'd4
    } t_phase;

    // msb first, not reflected
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/rlfp_rx_if.sv
// received byte channel
`timescale 1ns / 1ps
interface rlfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/rlfp_ch_if.sv
// unpacked channel value channel
`timescale 1ns / 1ps
interface rlfp_ch_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

### rtl/core/rc_link_frame_parser.sv
// rc link frame parser top level: frame hunting, crc check and channel unpacking
//
// i_rx carries one received byte per item; o_ch gives one unpacked channel
// value per item. A valid channel frame (right type, length 24, good crc)
// gives 16 items, channel 0 first, last_channel set on channel 15; other
// frames give nothing. Bytes are taken one per cycle while i_rx.ready is
// high. The 22 payload bytes sit in a memory with a registered read; after
// the crc byte is taken the unpacker streams it one byte at a time through
// a bit accumulator, fetching only while fewer than 11 bits are held or in
// flight. Each channel value goes out through the output register.
// While a run drains, i_rx keeps taking bytes; ready drops only when a
// payload byte would overwrite an entry the unpacker has not read yet, or
// when a crc byte arrives before the previous run is finished.
// A stalled o_ch holds its item and stops the unpacker. Synchronous reset
// returns to hunting for sync, empties the output and loads the register
// defaults (sync 0xC8, max length 62, channel type 0x16). Registers sit on
// an apb-style port at byte addresses 0, 4 and 8; they are to be written
// only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module rc_link_frame_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rlfp_rx_if.sink                      i_rx,
    rlfp_ch_if.source                    o_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rlfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // configuration
    logic [7:0] r_sync;
    logic [5:0] r_max_len;
    logic [7:0] r_ch_type;
    logic       cfg_wr;
    rlfp_pkg::t_reg_idx cfg_idx;

    // parser
    rlfp_pkg::t_phase r_phase, n_phase;
    logic [5:0] r_len, n_len;
    logic [5:0] r_rem, n_rem;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_type, n_type;
    logic [5:0] pos;
    logic       pos_in_store;
    logic       in_take;
    logic       frame_ok;
    logic       mem_wr;
    logic [7:0] crc_next;

    // payload store and unpacker
    logic [7:0] mem [rlfp_pkg::STORE_DEPTH];
    logic [7:0] r_rd_data;
    logic [rlfp_pkg::STORE_AW-1:0] r_rd_addr;
    logic       r_rd_pend;
    logic       r_busy;
    logic [rlfp_pkg::ACC_W-1:0] r_acc;
    logic [rlfp_pkg::ACC_CNT_W-1:0] r_acc_cnt;
    logic [3:0] r_ch;
    logic [rlfp_pkg::ACC_CNT_W-1:0] pend_cnt;
    logic [rlfp_pkg::ACC_CNT_W-1:0] cnt_after;
    logic [rlfp_pkg::ACC_W-1:0] acc_after;
    logic       fetch;
    logic       emit;
    logic       ch_last;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_out_idx;
    logic [10:0] r_out_val;
    logic        r_out_last;

    logic wr_conflict;
    logic crc_stall;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_idx = rlfp_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= rlfp_pkg::SYNC_RESET;
            r_max_len <= rlfp_pkg::MAX_LEN_RESET;
            r_ch_type <= rlfp_pkg::TYPE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rlfp_pkg::REG_SYNC:    r_sync <= pwdata[7:0];
                rlfp_pkg::REG_MAX_LEN: r_max_len <= pwdata[5:0];
                rlfp_pkg::REG_CH_TYPE: r_ch_type <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rlfp_pkg::REG_SYNC:    prdata = {24'd0, r_sync};
            rlfp_pkg::REG_MAX_LEN: prdata = {26'd0, r_max_len};
            rlfp_pkg::REG_CH_TYPE: prdata = {24'd0, r_ch_type};
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- parser ----------------
    assign pos = r_len - 6'd2 - r_rem;
    assign pos_in_store = pos < 6'(rlfp_pkg::STORE_DEPTH);

    // do not overwrite an entry the unpacker still has to read
    assign wr_conflict = (r_phase == rlfp_pkg::PH_PAYLOAD) && pos_in_store && r_busy
                         && (pos[rlfp_pkg::STORE_AW-1:0] >= r_rd_addr);
    assign crc_stall = (r_phase == rlfp_pkg::PH_CRC) && r_busy;
    assign i_rx.ready = !(wr_conflict || crc_stall);
    assign in_take = i_rx.valid && i_rx.ready;

    assign crc_next = rlfp_pkg::crc8_step(r_crc, i_rx.rx_byte);
    assign frame_ok = (i_rx.rx_byte == r_crc) && (r_type == r_ch_type)
                      && (r_len == rlfp_pkg::CHANNEL_FRAME_LEN);
    assign mem_wr = in_take && (r_phase == rlfp_pkg::PH_PAYLOAD) && pos_in_store;

    always_comb begin
        n_phase = r_phase;
        n_len = r_len;
        n_rem = r_rem;
        n_crc = r_crc;
        n_type = r_type;
        if (in_take) begin
            case (r_phase)
                rlfp_pkg::PH_LEN: begin
                    if (i_rx.rx_byte >= 8'd2 && i_rx.rx_byte <= {2'b00, r_max_len}) begin
                        n_len = i_rx.rx_byte[5:0];
                        n_rem = i_rx.rx_byte[5:0] - 6'd1;
                        n_crc = 8'd0;
                        n_phase = rlfp_pkg::PH_TYPE;
                    end else if (i_rx.rx_byte == r_sync) begin
                        n_phase = rlfp_pkg::PH_LEN;
                    end else begin
                        n_phase = rlfp_pkg::PH_HUNT;
                    end
                end
                rlfp_pkg::PH_TYPE: begin
                    n_type = i_rx.rx_byte;
                    n_crc = crc_next;
                    n_rem = r_rem - 6'd1;
                    n_phase = (n_rem == 6'd0) ? rlfp_pkg::PH_CRC : rlfp_pkg::PH_PAYLOAD;
                end
                rlfp_pkg::PH_PAYLOAD: begin
                    n_crc = crc_next;
                    n_rem = r_rem - 6'd1;
                    if (n_rem == 6'd0) begin
                        n_phase = rlfp_pkg::PH_CRC;
                    end
                end
                rlfp_pkg::PH_CRC: begin
                    n_phase = rlfp_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx.rx_byte == r_sync) ? rlfp_pkg::PH_LEN
                                                       : rlfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rlfp_pkg::PH_HUNT;
            r_len <= 6'd0;
            r_rem <= 6'd0;
            r_crc <= 8'd0;
            r_type <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len <= n_len;
            r_rem <= n_rem;
            r_crc <= n_crc;
            r_type <= n_type;
        end
    end

    // ---------------- payload store ----------------
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[pos[rlfp_pkg::STORE_AW-1:0]] <= i_rx.rx_byte;
        end
        if (fetch) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // ---------------- unpacker ----------------
    // bits held plus the byte still in flight
    assign pend_cnt = r_acc_cnt + (r_rd_pend ? rlfp_pkg::ACC_CNT_W'(8) : '0);
    assign fetch = r_busy && (r_rd_addr < rlfp_pkg::STORE_AW'(rlfp_pkg::STORE_DEPTH))
                   && (pend_cnt < rlfp_pkg::ACC_CNT_W'(rlfp_pkg::CHANNEL_BITS));
    assign emit = r_busy && (r_acc_cnt >= rlfp_pkg::ACC_CNT_W'(rlfp_pkg::CHANNEL_BITS))
                  && (!r_out_valid || o_ch.ready);
    assign ch_last = (r_ch == 4'(rlfp_pkg::NUM_CHANNELS - 1));
    assign cnt_after = emit ? r_acc_cnt - rlfp_pkg::ACC_CNT_W'(rlfp_pkg::CHANNEL_BITS)
                            : r_acc_cnt;
    assign acc_after = emit ? (r_acc >> rlfp_pkg::CHANNEL_BITS) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_addr <= '0;
            r_acc_cnt <= '0;
            r_ch <= 4'd0;
        end else begin
            if (in_take && r_phase == rlfp_pkg::PH_CRC && frame_ok) begin
                r_busy <= 1'b1;
                r_rd_pend <= 1'b0;
                r_rd_addr <= '0;
                r_acc_cnt <= '0;
                r_ch <= 4'd0;
            end else begin
                r_rd_pend <= fetch;
                if (fetch) begin
                    r_rd_addr <= r_rd_addr + rlfp_pkg::STORE_AW'(1);
                end
                r_acc_cnt <= cnt_after + (r_rd_pend ? rlfp_pkg::ACC_CNT_W'(8) : '0);
                if (emit) begin
                    r_ch <= r_ch + 4'd1;
                    if (ch_last) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    // bits above the held count stay zero, so each new byte is simply or-ed in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_rd_pend) begin
            r_acc <= acc_after
                     | (rlfp_pkg::ACC_W'(r_rd_data) << cnt_after);
        end else begin
            r_acc <= acc_after;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx <= r_ch;
            r_out_val <= r_acc[rlfp_pkg::CHANNEL_BITS-1:0];
            r_out_last <= ch_last;
        end
    end

    assign o_ch.valid = r_out_valid;
    assign o_ch.channel_index = r_out_idx;
    assign o_ch.channel_value = r_out_val;
    assign o_ch.last_channel = r_out_last;

endmodule
